// ===== sv/rvat_pkg.sv =====
// Shared types and constants for the RVA to file offset translator.
// Depends on nothing; used by every module of the block by scoped names.
package rvat_pkg;

  // Section table depth
  localparam int MAX_SECTIONS = 128;
  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  // Field widths
  localparam int ADDR_W = 64;
  localparam int SECT_W = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // Request types
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOADED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_ADDRESS = 1'd1;

  // One stored section
  typedef struct packed {
    logic [SECT_W-1:0] start;
    logic [SECT_W-1:0] span;
    logic [SECT_W-1:0] raw_pointer;
  } sect_t;

  // Outcome of testing one section against an address
  typedef struct packed {
    logic covers;
    logic [ADDR_W-1:0] offset;
  } match_t;

endpackage

// ===== sv/rva_to_file_offset_translator.sv =====
// Translates a relative virtual address into a file offset using a table of
// up to MAX_SECTIONS sections filled by append beats. The block takes one
// item at a time. An append, a translation in loaded mode or a lookup on an
// empty table passes from idle straight to the emit state, which loads the
// output register; a lookup with a valid last-hit cache first tests the
// cached slot in the cache state. Otherwise, or after a cache miss, the
// sections are scanned in order through the section memory's single read
// port, one section per cycle, until a hit or the last stored section, up
// to MAX_SECTIONS. The scan length sets the worst case. The input is ready
// again once the result is loaded, and a full output register stalls that
// load until it drains. A new item may be accepted while the previous
// result still waits on the output.
// Depends on rvat_pkg, rvat_sect_mem and rvat_match.
module rva_to_file_offset_translator (
  input  logic                                clk,
  input  logic                                rst,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [rvat_pkg::ADDR_W-1:0]         rva,
  input  logic [rvat_pkg::SECT_W-1:0]         section_start,
  input  logic [rvat_pkg::SECT_W-1:0]         section_span,
  input  logic [rvat_pkg::SECT_W-1:0]         section_raw_pointer,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rvat_pkg::ADDR_W-1:0]         file_offset,
  output logic [rvat_pkg::STATUS_W-1:0]       status,
  output logic                                cache_hit,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rvat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rvat_pkg::ADDR_W-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CACHE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic                        loaded_mode;
  logic [rvat_pkg::ADDR_W-1:0] load_address;

  // Table and cache control
  logic [rvat_pkg::CNT_W-1:0] section_count;
  logic                       cache_valid;
  logic [rvat_pkg::IDX_W-1:0] cache_slot;
  logic [rvat_pkg::IDX_W-1:0] chk_idx;

  // Held request address and pending result
  logic [rvat_pkg::ADDR_W-1:0]   req_addr;
  logic [rvat_pkg::ADDR_W-1:0]   res_offset;
  logic [rvat_pkg::STATUS_W-1:0] res_status;
  logic                          res_hit;

  // Memory and compare unit hookup
  logic                        accept;
  logic                        table_full;
  logic                        wr_en;
  rvat_pkg::sect_t             wr_data;
  logic [rvat_pkg::IDX_W-1:0]  rd_addr;
  rvat_pkg::sect_t             rd_data;
  rvat_pkg::match_t            match;
  logic                        last_slot;

  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign table_full = (section_count >= rvat_pkg::CNT_W'(rvat_pkg::MAX_SECTIONS));

  assign wr_en = accept && (req_type == rvat_pkg::REQ_APPEND) && !table_full;
  assign wr_data = '{start: section_start, span: section_span,
                     raw_pointer: section_raw_pointer};

  // Select the section to fetch for the next check
  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = cache_valid ? cache_slot : '0;
      ST_CACHE: rd_addr = '0;
      ST_SCAN:  rd_addr = chk_idx + rvat_pkg::IDX_W'(1);
      ST_EMIT:  rd_addr = '0;
      default:  rd_addr = '0;
    endcase
  end

  assign last_slot = ((rvat_pkg::CNT_W'(chk_idx) + rvat_pkg::CNT_W'(1)) == section_count);

  rvat_sect_mem u_sect_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (section_count[rvat_pkg::IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rvat_match u_match (
    .sect   (rd_data),
    .addr   (req_addr),
    .result (match)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_mode <= 1'b0;
      load_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rvat_pkg::REG_LOADED_MODE:  loaded_mode <= cfg_data[0];
        rvat_pkg::REG_LOAD_ADDRESS: load_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: accept, check cache, scan, hand result to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      section_count <= '0;
      cache_valid <= 1'b0;
      cache_slot <= '0;
      chk_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_addr <= rva;
            res_offset <= '0;
            res_status <= rvat_pkg::STATUS_OK;
            res_hit <= 1'b0;
            chk_idx <= '0;
            if (req_type == rvat_pkg::REQ_APPEND) begin
              if (table_full) begin
                res_status <= rvat_pkg::STATUS_FULL;
              end else begin
                section_count <= section_count + rvat_pkg::CNT_W'(1);
              end
              state <= ST_EMIT;
            end else if (loaded_mode) begin
              res_offset <= load_address + rva;
              state <= ST_EMIT;
            end else if (cache_valid) begin
              state <= ST_CACHE;
            end else if (section_count == '0) begin
              res_status <= rvat_pkg::STATUS_MISS;
              state <= ST_EMIT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_CACHE: begin
          if (match.covers) begin
            res_offset <= match.offset;
            res_hit <= 1'b1;
            state <= ST_EMIT;
          end else begin
            chk_idx <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match.covers) begin
            res_offset <= match.offset;
            cache_valid <= 1'b1;
            cache_slot <= chk_idx;
            state <= ST_EMIT;
          end else if (last_slot) begin
            res_status <= rvat_pkg::STATUS_MISS;
            state <= ST_EMIT;
          end else begin
            chk_idx <= chk_idx + rvat_pkg::IDX_W'(1);
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && (!out_valid || out_ready)) begin
      file_offset <= res_offset;
      status <= res_status;
      cache_hit <= res_hit;
    end
  end

  // Table never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    section_count <= rvat_pkg::CNT_W'(rvat_pkg::MAX_SECTIONS))
    else $error("section count exceeds table depth");

  // Cached slot always names a stored section
  a_cache_stored: assert property (@(posedge clk) disable iff (rst)
    cache_valid |-> (rvat_pkg::CNT_W'(cache_slot) < section_count))
    else $error("cache points past stored sections");

  // Scan only visits stored sections
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rvat_pkg::CNT_W'(chk_idx) < section_count))
    else $error("scan index past stored sections");

  // A stored append bumps the count by one
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (section_count == $past(section_count) + rvat_pkg::CNT_W'(1)))
    else $error("append did not advance section count");

  // Cache hits carry an ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cache_hit) |-> (status == rvat_pkg::STATUS_OK))
    else $error("cache hit with non-ok status");

endmodule

// ===== sv/rvat_sect_mem.sv =====
// Section table storage: one write port, one read port with registered data.
// Depends on rvat_pkg for the entry type and depth.
module rvat_sect_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [rvat_pkg::IDX_W-1:0] wr_addr,
  input  rvat_pkg::sect_t           wr_data,
  input  logic [rvat_pkg::IDX_W-1:0] rd_addr,
  output rvat_pkg::sect_t           rd_data
);

  rvat_pkg::sect_t mem [rvat_pkg::MAX_SECTIONS];

  // Write an appended section
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/rvat_match.sv =====
// Shared section compare and map unit: tests one section against an address
// and forms the file offset. Depends on rvat_pkg for sect_t and match_t.
module rvat_match (
  input  rvat_pkg::sect_t             sect,
  input  logic [rvat_pkg::ADDR_W-1:0] addr,
  output rvat_pkg::match_t            result
);

  logic [rvat_pkg::SECT_W-1:0] sect_end;
  logic [rvat_pkg::SECT_W-1:0] addr_lo;
  logic                        upper_zero;
  logic [rvat_pkg::SECT_W-1:0] delta;
  logic [rvat_pkg::SECT_W:0]   mapped;

  // Section end wraps at 32 bits
  assign sect_end = sect.start + sect.span;
  assign addr_lo = addr[rvat_pkg::SECT_W-1:0];
  assign upper_zero = (addr[rvat_pkg::ADDR_W-1:rvat_pkg::SECT_W] == '0);

  // A covered address is below 2^32 and at or above start, so the
  // difference fits in 32 bits and the mapped offset in 33
  assign delta = addr_lo - sect.start;
  assign mapped = {1'b0, delta} + {1'b0, sect.raw_pointer};

  assign result.covers = upper_zero && (addr_lo >= sect.start) && (addr_lo < sect_end);
  assign result.offset = {{(rvat_pkg::ADDR_W - rvat_pkg::SECT_W - 1){1'b0}}, mapped};

endmodule
